### rtl/core/tcce_pkg.sv
// Shared types and constants of the text console cursor engine.
`default_nettype none
package tcce_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_COPY
    } tcce_state_t;

    localparam logic [1:0] CMD_PUT  = 2'd0;
    localparam logic [1:0] CMD_SET  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_HT = 8'h09;
    localparam logic [7:0] CH_VT = 8'h0b;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;

    localparam logic [7:0] COLOR_RESET = 8'h20;

    typedef struct packed {
        logic we;
        logic re;
    } tcce_mem_ctl_t;

endpackage
`default_nettype wire

### rtl/core/text_console_cursor_engine.sv
// Text console engine top level: color register, sequencer and screen store.
//
// Commands arrive on the in_valid/in_ready channel, one word per command:
// cmd 0 puts char_code (control bytes move the cursor), cmd 1 sets the cursor
// from col and row (saturated to the screen), cmd 2 reads one cell.
// Each command returns one word on out_valid/out_ready with the cursor
// position after the command and, for a read, the cell's character and color.
// Put and set post their result from the execute state; a read passes through
// a further state for the registered read of the screen memory.
// Commands are handled one at a time: a new one is taken only after the
// previous one has posted its result.
// A put that moves the cursor past the last row scrolls: its result is posted
// at once, then the memory port copies each row up and zeroes the last row,
// which holds off new commands until the copy and the zeroing are done.
// After reset the block zeroes the whole store, one cell a cycle, before
// in_ready rises; the cursor is 0 and the color register holds 0x20.
// A stalled receiver keeps the result in the output register; one more
// command is accepted meanwhile and waits until that result is taken.
// cfg_we writes cfg_wdata into the color register; write it only while idle.
`default_nettype none
module text_console_cursor_engine #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_ready,
    input  wire [1:0]   cmd,
    input  wire [7:0]   char_code,
    input  wire [6:0]   col,
    input  wire [4:0]   row,
    output logic        out_valid,
    input  wire         out_ready,
    output logic [10:0] cursor_pos,
    output logic [7:0]  cell_char,
    output logic [7:0]  cell_color,
    output logic        scrolled,
    input  wire         cfg_we,
    input  wire [7:0]   cfg_wdata
);
    import tcce_pkg::*;

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [7:0]        text_color_reg;
    tcce_mem_ctl_t     mem_ctl;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic [15:0]       mem_wdata;
    logic [15:0]       mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= COLOR_RESET;
        end
        else if (cfg_we)
        begin
            text_color_reg <= cfg_wdata;
        end
    end

    tcce_ctrl #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .char_code  (char_code),
        .col        (col),
        .row        (row),
        .text_color (text_color_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cursor_pos (cursor_pos),
        .cell_char  (cell_char),
        .cell_color (cell_color),
        .scrolled   (scrolled),
        .mem_ctl    (mem_ctl),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    tcce_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .ctl     (mem_ctl),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr   (mem_raddr),
        .rd_data (mem_rdata)
    );

endmodule
`default_nettype wire

### rtl/core/tcce_screen_ram.sv
// Screen cell store: one write port, one read port with registered data.
`default_nettype none
module tcce_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  wire                 clk,
    input  tcce_pkg::tcce_mem_ctl_t ctl,
    input  wire [ADDR_W-1:0]    waddr,
    input  wire [15:0]          wdata,
    input  wire [ADDR_W-1:0]    raddr,
    output logic [15:0]         rd_data
);
    import tcce_pkg::*;

    logic [15:0] cell_mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.we)
        begin
            cell_mem[waddr] <= wdata;
        end
        if (ctl.re)
        begin
            rd_data_reg <= cell_mem[raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/core/tcce_ctrl.sv
// Command sequencer: cursor, cell writes and reads, scroll copy and clear sweeps.
`default_nettype none
module tcce_ctrl #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire [1:0]           cmd,
    input  wire [7:0]           char_code,
    input  wire [6:0]           col,
    input  wire [4:0]           row,
    input  wire [7:0]           text_color,
    output logic                out_valid,
    input  wire                 out_ready,
    output logic [10:0]         cursor_pos,
    output logic [7:0]          cell_char,
    output logic [7:0]          cell_color,
    output logic                scrolled,
    output tcce_pkg::tcce_mem_ctl_t mem_ctl,
    output logic [$clog2(COLS*ROWS)-1:0] mem_waddr,
    output logic [15:0]         mem_wdata,
    output logic [$clog2(COLS*ROWS)-1:0] mem_raddr,
    input  wire [15:0]          mem_rdata
);
    import tcce_pkg::*;

    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);

    tcce_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]         cmd_reg, cmd_next;
    logic [7:0]         ch_reg, ch_next;
    logic [COL_W-1:0]   arg_col_reg, arg_col_next;
    logic [ROW_W-1:0]   arg_row_reg, arg_row_next;
    logic [COL_W-1:0]   cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]   cur_row_reg, cur_row_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic               out_valid_reg, out_valid_next;
    logic [10:0]        cursor_pos_reg, cursor_pos_next;
    logic [7:0]         cell_char_reg, cell_char_next;
    logic [7:0]         cell_color_reg, cell_color_next;
    logic               scrolled_reg, scrolled_next;

    logic               out_free;
    logic [8:0]         col_wide;
    logic [6:0]         row_wide;
    logic [COL_W-1:0]   col_sat;
    logic [ROW_W-1:0]   row_sat;
    logic [ADDR_W-1:0]  cur_lin;
    logic [ADDR_W-1:0]  arg_lin;
    logic [ROW_W:0]     row_tmp;
    logic [COL_W-1:0]   col_tmp;
    logic               col_last;

    assign out_free = !out_valid_reg || out_ready;

    // Out-of-range positions saturate to the last column and row.
    assign col_wide = 9'(col);
    assign row_wide = 7'(row);
    assign col_sat = (col_wide > 9'(COLS - 1)) ? COL_W'(COLS - 1) : COL_W'(col_wide);
    assign row_sat = (row_wide > 7'(ROWS - 1)) ? ROW_W'(ROWS - 1) : ROW_W'(row_wide);

    assign cur_lin = ADDR_W'(32'(cur_row_reg) * 32'(COLS) + 32'(cur_col_reg));
    assign arg_lin = ADDR_W'(32'(arg_row_reg) * 32'(COLS) + 32'(arg_col_reg));
    assign col_last = (cur_col_reg == COL_W'(COLS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            cur_col_reg   <= '0;
            cur_row_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cur_col_reg   <= cur_col_next;
            cur_row_reg   <= cur_row_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        ch_reg         <= ch_next;
        arg_col_reg    <= arg_col_next;
        arg_row_reg    <= arg_row_next;
        pend_addr_reg  <= pend_addr_next;
        cursor_pos_reg <= cursor_pos_next;
        cell_char_reg  <= cell_char_next;
        cell_color_reg <= cell_color_next;
        scrolled_reg   <= scrolled_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmd_next        = cmd_reg;
        ch_next         = ch_reg;
        arg_col_next    = arg_col_reg;
        arg_row_next    = arg_row_reg;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        cursor_pos_next = cursor_pos_reg;
        cell_char_next  = cell_char_reg;
        cell_color_next = cell_color_reg;
        scrolled_next   = scrolled_reg;
        in_ready        = 1'b0;
        mem_ctl         = '0;
        mem_waddr       = cur_lin;
        mem_wdata       = {text_color, ch_reg};
        mem_raddr       = arg_lin;
        row_tmp         = {1'b0, cur_row_reg};
        col_tmp         = cur_col_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_ctl.we = 1'b1;
                mem_waddr  = cnt_reg[ADDR_W-1:0];
                mem_wdata  = '0;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next     = cmd;
                    ch_next      = char_code;
                    arg_col_next = col_sat;
                    arg_row_next = row_sat;
                    state_next   = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                if (out_free)
                begin
                    cell_char_next  = '0;
                    cell_color_next = '0;
                    scrolled_next   = 1'b0;
                    state_next      = ST_IDLE;
                    case (cmd_reg)
                        CMD_PUT:
                        begin
                            case (ch_reg)
                                CH_BS:
                                begin
                                    if (cur_col_reg != '0)
                                    begin
                                        col_tmp = cur_col_reg - 1'b1;
                                    end
                                    else if (cur_row_reg != '0)
                                    begin
                                        col_tmp = COL_W'(COLS - 1);
                                        row_tmp = {1'b0, cur_row_reg} - 1'b1;
                                    end
                                end
                                CH_VT:
                                begin
                                    row_tmp = {1'b0, cur_row_reg} + 1'b1;
                                end
                                CH_CR:
                                begin
                                    col_tmp = '0;
                                end
                                CH_LF:
                                begin
                                    col_tmp = '0;
                                    row_tmp = {1'b0, cur_row_reg} + 1'b1;
                                end
                                default:
                                begin
                                    // All other bytes, control bytes included, are stored; tab only advances.
                                    mem_ctl.we = (ch_reg != CH_HT);
                                    if (col_last)
                                    begin
                                        col_tmp = '0;
                                        row_tmp = {1'b0, cur_row_reg} + 1'b1;
                                    end
                                    else
                                    begin
                                        col_tmp = cur_col_reg + 1'b1;
                                    end
                                end
                            endcase
                            cur_col_next = col_tmp;
                            if (row_tmp == (ROW_W + 1)'(ROWS))
                            begin
                                cur_row_next  = ROW_W'(ROWS - 1);
                                scrolled_next = 1'b1;
                                cnt_next      = CNT_W'(COLS);
                                pend_next     = 1'b0;
                                state_next    = ST_COPY;
                            end
                            else
                            begin
                                cur_row_next = row_tmp[ROW_W-1:0];
                            end
                            out_valid_next = 1'b1;
                        end
                        CMD_SET:
                        begin
                            cur_col_next   = arg_col_reg;
                            cur_row_next   = arg_row_reg;
                            out_valid_next = 1'b1;
                        end
                        CMD_READ:
                        begin
                            mem_ctl.re = 1'b1;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                    cursor_pos_next = 11'(32'(cur_row_next) * 32'(COLS) + 32'(cur_col_next));
                end
            end

            ST_READ:
            begin
                if (out_free)
                begin
                    cell_char_next  = mem_rdata[7:0];
                    cell_color_next = mem_rdata[15:8];
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            ST_COPY:
            begin
                // Each word read at cnt is written one row up, at cnt - COLS, on the next cycle.
                if (pend_reg)
                begin
                    mem_ctl.we = 1'b1;
                    mem_waddr  = pend_addr_reg;
                    mem_wdata  = mem_rdata;
                end
                if (cnt_reg < CNT_W'(CELLS))
                begin
                    mem_ctl.re     = 1'b1;
                    mem_raddr      = cnt_reg[ADDR_W-1:0];
                    pend_next      = 1'b1;
                    pend_addr_next = ADDR_W'(cnt_reg - CNT_W'(COLS));
                    cnt_next       = cnt_reg + 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    cnt_next   = CNT_W'(CELLS - COLS);
                    state_next = ST_CLEAR;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign cursor_pos = cursor_pos_reg;
    assign cell_char  = cell_char_reg;
    assign cell_color = cell_color_reg;
    assign scrolled   = scrolled_reg;

endmodule
`default_nettype wire
